// File: src/udprv_pkg.sv
// Package for the UDP receive validator: widths, status codes, register map,
// the record passed from the accumulator to the result stage, and the
// ones'-complement adder. Used by every file of the block.
`default_nettype none

package udprv_pkg;

  // Item field widths
  localparam int BYTE_W    = 8;
  localparam int PSUM_W    = 24;
  localparam int WORD_W    = 16;
  localparam int ACC_W     = 32;
  localparam int COUNT_W   = 17;
  localparam int STATUS_W  = 3;

  // Datagram constants
  localparam int HEADER_BYTES = 8;
  localparam logic [WORD_W-1:0] DEFAULT_SERVICE_PORT = 16'd3478;

  // Result status codes, in check order
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SHORT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LEN_MISMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CHECKSUM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_PORT = 3'd4;

  // Register map: register index is paddr[CFG_ADDR_W-1:2]
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_SERVICE_PORT = 1'b0;

  // End-of-datagram record handed to the result stage
  typedef struct packed {
    logic [ACC_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic [WORD_W-1:0]  src;
    logic [WORD_W-1:0]  dst;
    logic [WORD_W-1:0]  len;
    logic [WORD_W-1:0]  csum;
  } fin_t;

  // 32-bit add with end-around carry
  function automatic logic [ACC_W-1:0] oc_add(input logic [ACC_W-1:0] a,
                                              input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W-1:0] + {{(ACC_W-1){1'b0}}, s[ACC_W]};
  endfunction

endpackage

`default_nettype wire

// File: src/udprv_in_if.sv
// Input channel of the UDP receive validator: one datagram byte per item.
// Depends on udprv_pkg for field widths.
`default_nettype none

interface udprv_in_if;
  import udprv_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [PSUM_W-1:0] pseudo_sum;
  logic              last_byte;

  modport source(output valid, data_byte, pseudo_sum, last_byte, input ready);
  modport sink(input valid, data_byte, pseudo_sum, last_byte, output ready);
endinterface

`default_nettype wire

// File: src/udprv_out_if.sv
// Result channel of the UDP receive validator: one status item per datagram.
// Depends on udprv_pkg for field widths.
`default_nettype none

interface udprv_out_if;
  import udprv_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   src_port;
  logic [WORD_W-1:0]   dst_port;
  logic [WORD_W-1:0]   payload_length;

  modport source(output valid, status, src_port, dst_port,
                 payload_length, input ready);
  modport sink(input valid, status, src_port, dst_port,
               payload_length, output ready);
endinterface

`default_nettype wire

// File: src/udprv_cfg.sv
// APB-style register port holding the service port register.
// Depends on udprv_pkg for the register map.
`default_nettype none

module udprv_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [udprv_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [udprv_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [udprv_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                  pready,
  output logic      [udprv_pkg::WORD_W-1:0]     service_port
);
  import udprv_pkg::*;

  logic [WORD_W-1:0]       service_port_r;
  logic [WORD_W-1:0]       service_port_nxt;
  logic [CFG_ADDR_W-3:0]   reg_idx;
  logic                    wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  // register write
  always_comb begin
    service_port_nxt = service_port_r;
    if (wr_en && reg_idx == REG_SERVICE_PORT) begin
      service_port_nxt = pwdata[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      service_port_r <= DEFAULT_SERVICE_PORT;
    end else begin
      service_port_r <= service_port_nxt;
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SERVICE_PORT) begin
      prdata = {{(CFG_DATA_W-WORD_W){1'b0}}, service_port_r};
    end
  end

  assign service_port = service_port_r;

endmodule

`default_nettype wire

// File: src/udprv_accum.sv
// Input register and per-datagram accumulator: byte count, header capture
// and running ones'-complement sum. Emits one record per datagram.
// Depends on udprv_pkg and udprv_in_if.
`default_nettype none

module udprv_accum (
  input  wire logic            clk,
  input  wire logic            rst_n,
  udprv_in_if.sink             in_if,
  output logic                 fin_valid,
  input  wire logic            fin_ready,
  output udprv_pkg::fin_t      fin_data
);
  import udprv_pkg::*;

  // input register
  logic              a_valid_r, a_valid_nxt;
  logic [BYTE_W-1:0] a_byte_r;
  logic [PSUM_W-1:0] a_ps_r;
  logic              a_last_r;

  // datagram state
  logic [COUNT_W-1:0] cnt_r,  cnt_nxt;
  logic [ACC_W-1:0]   acc_r,  acc_nxt;
  logic [BYTE_W-1:0]  held_r, held_nxt;
  logic [WORD_W-1:0]  src_r,  src_nxt;
  logic [WORD_W-1:0]  dst_r,  dst_nxt;
  logic [WORD_W-1:0]  len_r,  len_nxt;
  logic [WORD_W-1:0]  csum_r, csum_nxt;

  // output record
  logic f_valid_r, f_valid_nxt;
  fin_t fin_r, fin_nxt;

  // per-byte work
  logic               consume;
  logic               sat;
  logic               odd;
  logic               in_hdr;
  logic               add_en;
  logic [WORD_W-1:0]  word;
  logic [ACC_W-1:0]   base;
  logic [ACC_W-1:0]   sum_upd;
  logic [COUNT_W-1:0] cnt_upd;
  logic [BYTE_W-1:0]  held_upd;
  logic [WORD_W-1:0]  src_upd, dst_upd, len_upd, csum_upd;

  // a last byte needs a free record slot, other bytes always go through
  assign consume     = a_valid_r && (!a_last_r || !f_valid_r || fin_ready);
  assign in_if.ready = !a_valid_r || consume;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_if.ready) begin
      a_valid_nxt = in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      a_byte_r <= in_if.data_byte;
      a_ps_r   <= in_if.pseudo_sum;
      a_last_r <= in_if.last_byte;
    end
  end

  // sum update: odd byte completes a word; an even last byte is zero padded
  always_comb begin
    sat    = cnt_r[COUNT_W-1];
    odd    = cnt_r[0];
    in_hdr = (cnt_r[COUNT_W-1:3] == '0);
    base   = (cnt_r == '0) ? {{(ACC_W-PSUM_W){1'b0}}, a_ps_r} : acc_r;
    add_en = !sat && (odd || a_last_r);
    word   = odd ? {held_r, a_byte_r} : {a_byte_r, {BYTE_W{1'b0}}};
    sum_upd = add_en ? oc_add(base, {{(ACC_W-WORD_W){1'b0}}, word}) : base;
    cnt_upd  = sat ? cnt_r : cnt_r + 1'b1;
    held_upd = (!sat && !odd) ? a_byte_r : held_r;
  end

  // header capture, high byte first
  always_comb begin
    src_upd  = src_r;
    dst_upd  = dst_r;
    len_upd  = len_r;
    csum_upd = csum_r;
    if (in_hdr) begin
      unique case (cnt_r[2:1])
        2'd0: begin
          if (odd) src_upd[BYTE_W-1:0] = a_byte_r;
          else     src_upd[WORD_W-1:BYTE_W] = a_byte_r;
        end
        2'd1: begin
          if (odd) dst_upd[BYTE_W-1:0] = a_byte_r;
          else     dst_upd[WORD_W-1:BYTE_W] = a_byte_r;
        end
        2'd2: begin
          if (odd) len_upd[BYTE_W-1:0] = a_byte_r;
          else     len_upd[WORD_W-1:BYTE_W] = a_byte_r;
        end
        2'd3: begin
          if (odd) csum_upd[BYTE_W-1:0] = a_byte_r;
          else     csum_upd[WORD_W-1:BYTE_W] = a_byte_r;
        end
        default: ;
      endcase
    end
  end

  // state and record next values; last byte clears the datagram state
  always_comb begin
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    held_nxt    = held_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    len_nxt     = len_r;
    csum_nxt    = csum_r;
    fin_nxt     = fin_r;
    f_valid_nxt = f_valid_r && !fin_ready;
    if (consume) begin
      if (a_last_r) begin
        cnt_nxt      = '0;
        acc_nxt      = '0;
        held_nxt     = '0;
        src_nxt      = '0;
        dst_nxt      = '0;
        len_nxt      = '0;
        csum_nxt     = '0;
        f_valid_nxt  = 1'b1;
        fin_nxt.sum   = sum_upd;
        fin_nxt.count = cnt_upd;
        fin_nxt.src   = src_upd;
        fin_nxt.dst   = dst_upd;
        fin_nxt.len   = len_upd;
        fin_nxt.csum  = csum_upd;
      end else begin
        cnt_nxt  = cnt_upd;
        acc_nxt  = sum_upd;
        held_nxt = held_upd;
        src_nxt  = src_upd;
        dst_nxt  = dst_upd;
        len_nxt  = len_upd;
        csum_nxt = csum_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      acc_r     <= '0;
      held_r    <= '0;
      src_r     <= '0;
      dst_r     <= '0;
      len_r     <= '0;
      csum_r    <= '0;
      f_valid_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      acc_r     <= acc_nxt;
      held_r    <= held_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      len_r     <= len_nxt;
      csum_r    <= csum_nxt;
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

  assign fin_valid = f_valid_r;
  assign fin_data  = fin_r;

endmodule

`default_nettype wire

// File: src/udprv_final.sv
// Result stage: adds the length field, folds the checksum, runs the checks
// in order and holds the status item in the output register.
// Depends on udprv_pkg and udprv_out_if.
`default_nettype none

module udprv_final (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fin_valid,
  output logic                              fin_ready,
  input  wire udprv_pkg::fin_t              fin_data,
  input  wire logic [udprv_pkg::WORD_W-1:0] service_port,
  udprv_out_if.source                       out_if
);
  import udprv_pkg::*;

  logic                 o_valid_r, o_valid_nxt;
  logic [STATUS_W-1:0]  status_r;
  logic [WORD_W-1:0]    src_r, dst_r, plen_r;

  logic [ACC_W-1:0]     sum_len;
  logic [WORD_W:0]      fold1, fold2, fold3;
  logic [STATUS_W-1:0]  status_c;
  logic [WORD_W-1:0]    plen_c;
  logic                 short_dg;
  logic                 load;

  assign fin_ready = !o_valid_r || out_if.ready;
  assign load      = fin_valid && fin_ready;

  // length add and three-step fold to 16 bits
  always_comb begin
    sum_len = oc_add(fin_data.sum, {{(ACC_W-WORD_W){1'b0}}, fin_data.len});
    fold1   = {1'b0, sum_len[WORD_W-1:0]} + {1'b0, sum_len[ACC_W-1:WORD_W]};
    fold2   = {1'b0, fold1[WORD_W-1:0]} + {{WORD_W{1'b0}}, fold1[WORD_W]};
    fold3   = {1'b0, fold2[WORD_W-1:0]} + {{WORD_W{1'b0}}, fold2[WORD_W]};
  end

  // checks, first failure wins
  always_comb begin
    short_dg = fin_data.count < COUNT_W'(HEADER_BYTES);
    plen_c   = short_dg ? '0 : fin_data.count[WORD_W-1:0] - WORD_W'(HEADER_BYTES);
    priority if (short_dg) begin
      status_c = ST_TOO_SHORT;
    end else if (fin_data.count[COUNT_W-1] ||
                 {1'b0, fin_data.len} != fin_data.count) begin
      status_c = ST_LEN_MISMATCH;
    end else if (fin_data.csum != '0 && fold3 != {1'b0, {WORD_W{1'b1}}}) begin
      status_c = ST_BAD_CHECKSUM;
    end else if (fin_data.dst != service_port) begin
      status_c = ST_UNKNOWN_PORT;
    end else begin
      status_c = ST_OK;
    end
  end

  // output register
  always_comb begin
    o_valid_nxt = o_valid_r && !out_if.ready;
    if (load) begin
      o_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_c;
      src_r    <= fin_data.src;
      dst_r    <= fin_data.dst;
      plen_r   <= plen_c;
    end
  end

  assign out_if.valid          = o_valid_r;
  assign out_if.status         = status_r;
  assign out_if.src_port       = src_r;
  assign out_if.dst_port       = dst_r;
  assign out_if.payload_length = plen_r;

endmodule

`default_nettype wire

// File: src/udp_receive_validator.sv
// UDP receive validator, top level.
// Input channel in_if: one datagram byte per item, header first in network
//   order; pseudo_sum is sampled with the first byte, last_byte marks the end.
// Result channel out_if: one item per datagram, issued for its last byte,
//   with status (ok, too short, length mismatch, bad checksum, unknown port),
//   the captured ports and the payload length.
// Register port (psel/penable/...): service_port at byte address 0, the
//   destination port that is accepted; write it only while the block is idle.
// Throughput: one byte per clock while no last byte waits. The byte path is
//   an input register, one ones'-complement add in the accumulator, and a
//   result stage that folds the sum and runs the checks.
// Result path: the last byte passes the input register, then the record
//   register, then the result register, which raises out_if.valid.
// Reset (rst_n low, synchronous) empties all stages, clears the datagram
//   state and sets service_port to 3478.
// When the result receiver stalls, the result register holds and bytes keep
//   flowing; a last byte waits only while both the record slot and the
//   result register are full.
// Depends on udprv_pkg, udprv_in_if, udprv_out_if and the udprv_* modules.
`default_nettype none

module udp_receive_validator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  udprv_in_if.sink                              in_if,
  udprv_out_if.source                           out_if,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [udprv_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [udprv_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [udprv_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                  pready
);
  import udprv_pkg::*;

  logic              fin_valid;
  logic              fin_ready;
  fin_t              fin_data;
  logic [WORD_W-1:0] service_port;

  udprv_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .service_port (service_port)
  );

  udprv_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_data  (fin_data)
  );

  udprv_final u_final (
    .clk          (clk),
    .rst_n        (rst_n),
    .fin_valid    (fin_valid),
    .fin_ready    (fin_ready),
    .fin_data     (fin_data),
    .service_port (service_port),
    .out_if       (out_if)
  );

endmodule

`default_nettype wire

// File: src/udprv_checker.sv
// Port-level checker for the UDP receive validator, bound to the top level.
// Depends on udprv_pkg for status codes and widths.
`default_nettype none

module udprv_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [udprv_pkg::STATUS_W-1:0] status,
  input wire logic [udprv_pkg::WORD_W-1:0]   src_port,
  input wire logic [udprv_pkg::WORD_W-1:0]   dst_port,
  input wire logic [udprv_pkg::WORD_W-1:0]   payload_length
);
  import udprv_pkg::*;

  // a stalled result item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(src_port) && $stable(dst_port) && $stable(payload_length))
    else $error("result item changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // only the five defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= ST_UNKNOWN_PORT)
    else $error("undefined status code");

  // a short datagram has no payload
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_TOO_SHORT |-> payload_length == '0)
    else $error("short datagram with nonzero payload length");

  // an oversized datagram can never pass
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_OK |-> payload_length <= 16'hFFF7)
    else $error("ok status with oversized payload length");

endmodule

bind udp_receive_validator udprv_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .status         (out_if.status),
  .src_port       (out_if.src_port),
  .dst_port       (out_if.dst_port),
  .payload_length (out_if.payload_length)
);

`default_nettype wire

// File: tb/tb_udp_receive_validator.sv
// Self-checking testbench for udp_receive_validator: drives datagrams byte by
// byte, predicts each status item and checks it field by field.
// Depends on udprv_pkg, udprv_in_if, udprv_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_udp_receive_validator;
  import udprv_pkg::*;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES = 1150;
  localparam logic [COUNT_W-1:0] COUNT_FULL = 17'h10000;

  // One expected status item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   src;
    logic [WORD_W-1:0]   dst;
    logic [WORD_W-1:0]   payload;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  udprv_in_if  in_if ();
  udprv_out_if out_if ();

  udp_receive_validator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state for the datagram in progress
  logic [WORD_W-1:0]  svc_port;
  logic [COUNT_W-1:0] dg_count;
  logic [ACC_W-1:0]   dg_sum;
  logic [BYTE_W-1:0]  dg_hi;
  logic [WORD_W-1:0]  hdr_src;
  logic [WORD_W-1:0]  hdr_dst;
  logic [WORD_W-1:0]  hdr_len;
  logic [WORD_W-1:0]  hdr_csum;

  verdict_t          verdicts_due[$];
  logic [BYTE_W-1:0] frame[$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  cycles = 0;
  int  hold_len = 0;
  bit  sender_gaps = 1'b1;
  bit  receiver_gaps = 1'b1;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_udp_receive_validator failed");
    $finish;
  end

  task automatic flag(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // 32-bit add with end-around carry
  function automatic logic [ACC_W-1:0] wrap_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
    logic [ACC_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[ACC_W-1:0] + {{(ACC_W-1){1'b0}}, t[ACC_W]};
  endfunction

  function automatic logic [WORD_W-1:0] fold16(input logic [ACC_W-1:0] a);
    logic [ACC_W-1:0] s;
    s = {16'h0, a[15:0]} + {16'h0, a[31:16]};
    s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    return s[15:0];
  endfunction

  task automatic clear_datagram();
    dg_count = '0;
    dg_sum   = '0;
    dg_hi    = '0;
    hdr_src  = '0;
    hdr_dst  = '0;
    hdr_len  = '0;
    hdr_csum = '0;
  endtask

  // Advance the predictor by one accepted byte; queue a verdict on the last one
  task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic [PSUM_W-1:0] ps,
                             input logic last);
    logic [COUNT_W-1:0] idx;
    logic [WORD_W-1:0]  f;
    verdict_t           v;
    idx = dg_count;
    if (idx == 0) dg_sum = {8'h0, ps};
    if (idx < COUNT_FULL) begin
      case (idx)
        0: hdr_src[15:8]  = b;
        1: hdr_src[7:0]   = b;
        2: hdr_dst[15:8]  = b;
        3: hdr_dst[7:0]   = b;
        4: hdr_len[15:8]  = b;
        5: hdr_len[7:0]   = b;
        6: hdr_csum[15:8] = b;
        7: hdr_csum[7:0]  = b;
        default: ;
      endcase
      if (!idx[0]) dg_hi = b;
      else dg_sum = wrap_add(dg_sum, {16'h0, dg_hi, b});
      dg_count = idx + 1'b1;
    end
    if (last) begin
      if (dg_count < COUNT_FULL && dg_count[0])
        dg_sum = wrap_add(dg_sum, {16'h0, dg_hi, 8'h00});
      dg_sum = wrap_add(dg_sum, {16'h0, hdr_len});
      f = fold16(dg_sum);
      v.src = hdr_src;
      v.dst = hdr_dst;
      if (dg_count < HEADER_BYTES) begin
        v.status  = ST_TOO_SHORT;
        v.payload = '0;
      end else begin
        v.payload = 16'(dg_count - HEADER_BYTES);
        if (dg_count >= COUNT_FULL || {1'b0, hdr_len} != dg_count)
          v.status = ST_LEN_MISMATCH;
        else if (hdr_csum != 0 && f != 16'hFFFF)
          v.status = ST_BAD_CHECKSUM;
        else if (hdr_dst != svc_port)
          v.status = ST_UNKNOWN_PORT;
        else
          v.status = ST_OK;
      end
      verdicts_due.push_back(v);
      clear_datagram();
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdicts_due.size() == 0) begin
        flag("unexpected result, status", out_if.status, -1);
      end else begin
        want = verdicts_due.pop_front();
        if (out_if.status !== want.status)
          flag("status", out_if.status, want.status);
        if (out_if.src_port !== want.src)
          flag("src_port", out_if.src_port, want.src);
        if (out_if.dst_port !== want.dst)
          flag("dst_port", out_if.dst_port, want.dst);
        if (out_if.payload_length !== want.payload)
          flag("payload_length", out_if.payload_length, want.payload);
      end
    end
  end

  // Result receiver: random stall bursts, and a long hold-off on request
  initial begin
    int n;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one byte, with an optional idle burst first, and wait for acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [PSUM_W-1:0] ps,
                           input logic last);
    int gap;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.pseudo_sum <= ps;
    in_if.last_byte  <= last;
    do @(posedge clk); while (!in_if.ready);
    absorb_byte(b, ps, last);
    bytes_sent++;
  endtask

  // Send the frame buffer as one datagram; pseudo sum is random after byte 0
  task automatic send_frame(input logic [PSUM_W-1:0] ps);
    int i;
    for (i = 0; i < frame.size(); i++)
      send_byte(frame[i], (i == 0) ? ps : PSUM_W'($urandom), i == frame.size() - 1);
  endtask

  // Header plus random payload; checksum field left zero
  task automatic make_frame(input logic [WORD_W-1:0] src, input logic [WORD_W-1:0] dst,
                            input int payload_n, input logic [WORD_W-1:0] len_field);
    int i;
    frame.delete();
    frame.push_back(src[15:8]);
    frame.push_back(src[7:0]);
    frame.push_back(dst[15:8]);
    frame.push_back(dst[7:0]);
    frame.push_back(len_field[15:8]);
    frame.push_back(len_field[7:0]);
    frame.push_back(8'h00);
    frame.push_back(8'h00);
    for (i = 0; i < payload_n; i++)
      frame.push_back(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Fill in the checksum field so the whole datagram folds to all ones
  task automatic seal_frame(input logic [PSUM_W-1:0] ps);
    logic [ACC_W-1:0]  acc;
    logic [WORD_W-1:0] c;
    int i;
    frame[6] = 8'h00;
    frame[7] = 8'h00;
    acc = {8'h0, ps};
    for (i = 0; i + 1 < frame.size(); i += 2)
      acc = wrap_add(acc, {16'h0, frame[i], frame[i+1]});
    if (frame.size() % 2 != 0)
      acc = wrap_add(acc, {16'h0, frame[frame.size()-1], 8'h00});
    acc = wrap_add(acc, {16'h0, frame[4], frame[5]});
    c = ~fold16(acc);
    frame[6] = c[15:8];
    frame[7] = c[7:0];
  endtask

  // Stop offering and wait for every outstanding verdict, then let the pipe settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [WORD_W-1:0] port);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SERVICE_PORT, 2'b00};
    pwdata  <= {16'($urandom), port};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    svc_port = port;
  endtask

  task automatic cfg_read_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_SERVICE_PORT, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[WORD_W-1:0] !== svc_port)
      flag("service_port readback", prdata[WORD_W-1:0], svc_port);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register holds its reset value
  task automatic test_reset_value();
    cfg_read_check();
  endtask

  // Short datagrams, both checksum outcomes, length mismatch, check priority
  task automatic test_directed();
    // single byte, all ones
    frame.delete();
    frame.push_back(8'hFF);
    send_frame(24'hFFFFFF);
    // five bytes: destination port captured, length field half captured
    frame.delete();
    frame.push_back(8'h12);
    frame.push_back(8'h34);
    frame.push_back(8'h0D);
    frame.push_back(8'h96);
    frame.push_back(8'h00);
    send_frame(24'h000000);
    // header only, good checksum, largest pseudo sum
    make_frame(16'h0000, svc_port, 0, 16'd8);
    seal_frame(24'hFFFFFF);
    send_frame(24'hFFFFFF);
    // odd length, trailing byte padded
    make_frame(16'hFFFF, svc_port, 1, 16'd9);
    frame[8] = 8'hFF;
    seal_frame(24'h000000);
    send_frame(24'h000000);
    // corrupted source byte breaks the checksum
    make_frame(16'h1234, svc_port, 0, 16'd8);
    seal_frame(24'h00ABCD);
    frame[1] ^= 8'h01;
    send_frame(24'h00ABCD);
    // length, checksum and port all wrong: length mismatch wins
    make_frame(16'h4321, ~svc_port, 0, 16'd9);
    frame[7] = 8'h01;
    send_frame(24'h123456);
    // zero checksum field skips the check, port still rejected
    make_frame(16'hAAAA, svc_port ^ 16'h0001, 0, 16'd8);
    send_frame(24'h555555);
    drain();
  endtask

  // Service port at both extremes
  task automatic test_port_extremes();
    logic [PSUM_W-1:0] ps;
    int k;
    for (k = 0; k < 2; k++) begin
      cfg_write(k == 0 ? 16'hFFFF : 16'h0000);
      cfg_read_check();
      ps = PSUM_W'($urandom);
      make_frame(WORD_W'($urandom), svc_port, 3, 16'd11);
      seal_frame(ps);
      send_frame(ps);
      ps = PSUM_W'($urandom);
      make_frame(WORD_W'($urandom), svc_port ^ 16'h0001, 2, 16'd10);
      seal_frame(ps);
      send_frame(ps);
      drain();
    end
  endtask

  // Receiver holds off while the sender keeps pushing short datagrams
  task automatic test_backpressure();
    int k;
    int n;
    int i;
    sender_gaps = 1'b0;
    hold_len = 300;
    for (k = 0; k < 40; k++) begin
      n = $urandom_range(1, 3);
      frame.delete();
      for (i = 0; i < n; i++)
        frame.push_back(BYTE_W'($urandom));
      send_frame(PSUM_W'($urandom));
    end
    drain();
    sender_gaps = 1'b1;
  endtask

  // Mostly well-formed datagrams with random content, some damaged, some noise
  task automatic test_random_traffic();
    logic [PSUM_W-1:0] ps;
    logic [WORD_W-1:0] dst;
    int start;
    int kind;
    int n;
    int i;
    bit retuned;
    start = bytes_sent;
    retuned = 1'b0;
    cfg_write(WORD_W'($urandom));
    cfg_read_check();
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (!retuned && bytes_sent - start >= RANDOM_BYTES / 2) begin
        drain();
        cfg_write(WORD_W'($urandom));
        cfg_read_check();
        retuned = 1'b1;
      end
      // last stretch runs without idling
      if (bytes_sent - start >= RANDOM_BYTES - 200) begin
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
      end
      ps   = PSUM_W'($urandom);
      n    = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
      dst  = ($urandom_range(0, 6) == 0) ? WORD_W'($urandom) : svc_port;
      kind = $urandom_range(0, 19);
      make_frame(WORD_W'($urandom), dst, n, WORD_W'(8 + n));
      seal_frame(ps);
      case (kind)
        0, 1: frame[$urandom_range(0, frame.size() - 1)] ^= BYTE_W'($urandom_range(1, 255));
        2: begin
          frame[5] ^= BYTE_W'($urandom_range(1, 255));
          seal_frame(ps);
        end
        3: begin
          frame[6] = 8'h00;
          frame[7] = 8'h00;
        end
        4: begin
          n = $urandom_range(1, 7);
          while (frame.size() > n) void'(frame.pop_back());
        end
        5: begin
          n = $urandom_range(1, 20);
          frame.delete();
          for (i = 0; i < n; i++)
            frame.push_back(BYTE_W'($urandom));
        end
        default: ;
      endcase
      send_frame(ps);
    end
  endtask

  // Test sequence
  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.pseudo_sum = '0;
    in_if.last_byte = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    svc_port = DEFAULT_SERVICE_PORT;
    clear_datagram();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_value();
    test_directed();
    test_port_extremes();
    test_backpressure();
    test_random_traffic();
    drain();

    if (verdicts_due.size() != 0)
      flag("verdicts left over", verdicts_due.size(), 0);
    if (mismatches == 0)
      $display("tb_udp_receive_validator passed");
    else
      $display("tb_udp_receive_validator failed");
    $finish;
  end

endmodule

// File: sim.f
src/udprv_pkg.sv
src/udprv_in_if.sv
src/udprv_out_if.sv
src/udprv_cfg.sv
src/udprv_accum.sv
src/udprv_final.sv
src/udp_receive_validator.sv
src/udprv_checker.sv
tb/tb_udp_receive_validator.sv
